// ----- design/allm_pkg.sv -----
// Shared constants, types and helpers for the array linked list manager.
package allm_pkg;

    localparam int CAPACITY   = 64;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int LINK_W     = $clog2(CAPACITY + 1);
    localparam int KEY_W      = 32;
    localparam int OUT_SLOT_W = 6;
    localparam int STATUS_W   = 2;
    localparam int OP_W       = 2;

    // The nil link is one past the last slot.
    localparam logic [LINK_W-1:0] LINK_NIL = LINK_W'(CAPACITY);

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_INS_WR,
        S_INS_LINK,
        S_WALK,
        S_DEL_UNLINK,
        S_DEL_FREE,
        S_DONE
    } t_state;

    // Any link value that does not name a slot counts as nil.
    function automatic logic is_slot(input logic [LINK_W-1:0] link);
        return link < LINK_W'(CAPACITY);
    endfunction

endpackage

// ----- design/allm_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface allm_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [allm_pkg::OP_W-1:0]             operation;
    logic signed [allm_pkg::KEY_W-1:0]     key_value;

    modport source (output valid, output operation, output key_value, input ready);
    modport sink   (input valid, input operation, input key_value, output ready);
endinterface

interface allm_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [allm_pkg::OUT_SLOT_W-1:0]       slot_index;
    logic [allm_pkg::STATUS_W-1:0]         status;

    modport source (output valid, output slot_index, output status, input ready);
    modport sink   (input valid, input slot_index, input status, output ready);
endinterface

// ----- design/array_linked_list_manager_core.sv -----
// Doubly linked key list with a free list, kept in three synchronous memories.
//
//  Port   Dir  Payload                         Handshake
//  i_in   in   operation[1:0], key_value[31:0]  valid/ready, one transaction per request
//  o_out  out  slot_index[5:0], status[1:0]     valid/ready, one transaction per request
//
// Insert runs through S_INS_WR and, if the list is not empty, S_INS_LINK; a miss on
// an empty list or a full insert goes straight to S_DONE. Delete and search visit
// one slot per cycle through the key/next memory read port; a delete that hits then
// passes S_DEL_UNLINK and S_DEL_FREE. After reset a clearing pass over all CAPACITY
// slots initializes the memories; no request is taken during it. A result waits in
// an output register, and the next request is accepted while it is held; the core
// stalls only when a second result is ready before the first has been taken.
module array_linked_list_manager_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    allm_in_if.sink     i_in,
    allm_out_if.source  o_out
);

    localparam int SLOT_W = allm_pkg::SLOT_W;
    localparam int LINK_W = allm_pkg::LINK_W;
    localparam int KEY_W  = allm_pkg::KEY_W;

    // Memories.
    logic [KEY_W-1:0]  key_mem  [allm_pkg::CAPACITY];
    logic [LINK_W-1:0] next_mem [allm_pkg::CAPACITY];
    logic [LINK_W-1:0] prev_mem [allm_pkg::CAPACITY];

    logic              kn_re;
    logic [SLOT_W-1:0] kn_ra;
    logic              prev_re;
    logic [SLOT_W-1:0] prev_ra;
    logic [KEY_W-1:0]  rd_key;
    logic [LINK_W-1:0] rd_next;
    logic [LINK_W-1:0] rd_prev;

    logic              key_we;
    logic [SLOT_W-1:0] key_wa;
    logic [KEY_W-1:0]  key_wd;
    logic              next_we;
    logic [SLOT_W-1:0] next_wa;
    logic [LINK_W-1:0] next_wd;
    logic              prev_we;
    logic [SLOT_W-1:0] prev_wa;
    logic [LINK_W-1:0] prev_wd;

    // Control and datapath registers.
    allm_pkg::t_state  r_state, n_state;
    logic [LINK_W-1:0] r_head, n_head;
    logic [LINK_W-1:0] r_free, n_free;
    logic [LINK_W-1:0] r_cur, n_cur;
    logic [LINK_W-1:0] r_steps, n_steps;
    logic [SLOT_W-1:0] r_init_idx, n_init_idx;
    allm_pkg::t_op     r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [LINK_W-1:0] r_after, n_after;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;
    allm_pkg::t_status r_res_status, n_res_status;

    logic                            r_out_valid;
    logic [allm_pkg::OUT_SLOT_W-1:0] r_out_slot;
    allm_pkg::t_status               r_out_status;

    logic in_accept;
    logic out_free;
    logic out_load;
    logic key_match;
    logic walk_more;

    assign in_accept = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign out_load  = (r_state == allm_pkg::S_DONE) && out_free;
    assign key_match = (rd_key == r_key);
    // The walk goes on while the next link names a slot and the step bound is not hit.
    assign walk_more = allm_pkg::is_slot(rd_next) && (r_steps != LINK_W'(allm_pkg::CAPACITY));

    assign i_in.ready       = (r_state == allm_pkg::S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.slot_index = r_out_slot;
    assign o_out.status     = r_out_status;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            allm_pkg::S_INIT: begin
                if (r_init_idx == SLOT_W'(allm_pkg::CAPACITY - 1)) begin
                    n_state = allm_pkg::S_IDLE;
                end
            end
            allm_pkg::S_IDLE: begin
                if (in_accept) begin
                    case (allm_pkg::t_op'(i_in.operation))
                        allm_pkg::OP_INSERT: begin
                            n_state = allm_pkg::is_slot(r_free) ? allm_pkg::S_INS_WR
                                                                : allm_pkg::S_DONE;
                        end
                        allm_pkg::OP_DELETE, allm_pkg::OP_SEARCH: begin
                            n_state = allm_pkg::is_slot(r_head) ? allm_pkg::S_WALK
                                                                : allm_pkg::S_DONE;
                        end
                        default: n_state = allm_pkg::S_DONE;
                    endcase
                end
            end
            allm_pkg::S_INS_WR: begin
                n_state = allm_pkg::is_slot(r_head) ? allm_pkg::S_INS_LINK : allm_pkg::S_DONE;
            end
            allm_pkg::S_INS_LINK: n_state = allm_pkg::S_DONE;
            allm_pkg::S_WALK: begin
                if (key_match) begin
                    n_state = (r_op == allm_pkg::OP_DELETE) ? allm_pkg::S_DEL_UNLINK
                                                            : allm_pkg::S_DONE;
                end else if (!walk_more) begin
                    n_state = allm_pkg::S_DONE;
                end
            end
            allm_pkg::S_DEL_UNLINK: n_state = allm_pkg::S_DEL_FREE;
            allm_pkg::S_DEL_FREE:   n_state = allm_pkg::S_DONE;
            allm_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = allm_pkg::S_IDLE;
                end
            end
            default: n_state = allm_pkg::S_INIT;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        n_head       = r_head;
        n_free       = r_free;
        n_cur        = r_cur;
        n_steps      = r_steps;
        n_init_idx   = r_init_idx;
        n_op         = r_op;
        n_key        = r_key;
        n_slot       = r_slot;
        n_after      = r_after;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;

        kn_re   = 1'b0;
        kn_ra   = r_cur[SLOT_W-1:0];
        prev_re = 1'b0;
        prev_ra = r_cur[SLOT_W-1:0];
        key_we  = 1'b0;
        key_wa  = r_slot;
        key_wd  = r_key;
        next_we = 1'b0;
        next_wa = r_slot;
        next_wd = r_head;
        prev_we = 1'b0;
        prev_wa = r_slot;
        prev_wd = allm_pkg::LINK_NIL;

        case (r_state)
            allm_pkg::S_INIT: begin
                key_we     = 1'b1;
                key_wa     = r_init_idx;
                key_wd     = '0;
                next_we    = 1'b1;
                next_wa    = r_init_idx;
                next_wd    = LINK_W'(r_init_idx) + LINK_W'(1);
                prev_we    = 1'b1;
                prev_wa    = r_init_idx;
                prev_wd    = allm_pkg::LINK_NIL;
                n_init_idx = r_init_idx + SLOT_W'(1);
                n_head     = allm_pkg::LINK_NIL;
                n_free     = '0;
            end
            allm_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_op         = allm_pkg::t_op'(i_in.operation);
                    n_key        = i_in.key_value;
                    n_res_slot   = '0;
                    n_res_status = allm_pkg::ST_NOT_FOUND;
                    case (allm_pkg::t_op'(i_in.operation))
                        allm_pkg::OP_INSERT: begin
                            if (allm_pkg::is_slot(r_free)) begin
                                kn_re  = 1'b1;
                                kn_ra  = r_free[SLOT_W-1:0];
                                n_slot = r_free[SLOT_W-1:0];
                            end else begin
                                n_res_status = allm_pkg::ST_FULL;
                            end
                        end
                        allm_pkg::OP_DELETE, allm_pkg::OP_SEARCH: begin
                            if (allm_pkg::is_slot(r_head)) begin
                                kn_re   = 1'b1;
                                kn_ra   = r_head[SLOT_W-1:0];
                                n_cur   = r_head;
                                n_steps = LINK_W'(1);
                            end
                        end
                        default: begin
                            n_res_status = allm_pkg::ST_NOT_FOUND;
                        end
                    endcase
                end
            end
            allm_pkg::S_INS_WR: begin
                // The next link read at the free head becomes the new free head.
                key_we       = 1'b1;
                next_we      = 1'b1;
                next_wd      = r_head;
                prev_we      = 1'b1;
                prev_wd      = allm_pkg::LINK_NIL;
                n_free       = rd_next;
                n_res_slot   = r_slot;
                n_res_status = allm_pkg::ST_OK;
                if (!allm_pkg::is_slot(r_head)) begin
                    n_head = LINK_W'(r_slot);
                end
            end
            allm_pkg::S_INS_LINK: begin
                prev_we = 1'b1;
                prev_wa = r_head[SLOT_W-1:0];
                prev_wd = LINK_W'(r_slot);
                n_head  = LINK_W'(r_slot);
            end
            allm_pkg::S_WALK: begin
                if (key_match) begin
                    n_slot       = r_cur[SLOT_W-1:0];
                    n_after      = rd_next;
                    n_res_slot   = r_cur[SLOT_W-1:0];
                    n_res_status = allm_pkg::ST_OK;
                    if (r_op == allm_pkg::OP_DELETE) begin
                        prev_re = 1'b1;
                        prev_ra = r_cur[SLOT_W-1:0];
                    end
                end else if (walk_more) begin
                    // The next slot's address comes straight from the read data.
                    kn_re   = 1'b1;
                    kn_ra   = rd_next[SLOT_W-1:0];
                    n_cur   = rd_next;
                    n_steps = r_steps + LINK_W'(1);
                end else begin
                    n_res_slot   = '0;
                    n_res_status = allm_pkg::ST_NOT_FOUND;
                end
            end
            allm_pkg::S_DEL_UNLINK: begin
                if (allm_pkg::is_slot(rd_prev)) begin
                    next_we = 1'b1;
                    next_wa = rd_prev[SLOT_W-1:0];
                    next_wd = r_after;
                end else begin
                    n_head = r_after;
                end
                if (allm_pkg::is_slot(r_after)) begin
                    prev_we = 1'b1;
                    prev_wa = r_after[SLOT_W-1:0];
                    prev_wd = rd_prev;
                end
            end
            allm_pkg::S_DEL_FREE: begin
                next_we = 1'b1;
                next_wa = r_slot;
                next_wd = r_free;
                n_free  = LINK_W'(r_slot);
            end
            allm_pkg::S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // Memories: one write and one registered read per cycle each.
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_wa] <= key_wd;
        end
        if (kn_re) begin
            rd_key <= key_mem[kn_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (kn_re) begin
            rd_next <= next_mem[kn_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        if (prev_re) begin
            rd_prev <= prev_mem[prev_ra];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= allm_pkg::S_INIT;
            r_head      <= allm_pkg::LINK_NIL;
            r_free      <= '0;
            r_init_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_head     <= n_head;
            r_free     <= n_free;
            r_init_idx <= n_init_idx;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cur        <= n_cur;
        r_steps      <= n_steps;
        r_op         <= n_op;
        r_key        <= n_key;
        r_slot       <= n_slot;
        r_after      <= n_after;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_slot   <= allm_pkg::OUT_SLOT_W'(r_res_slot);
            r_out_status <= r_res_status;
        end
    end

endmodule
